/* sv/sfd_pkg.sv */
// shared types, constants and the check function of the sensor frame deframer
package sfd_pkg;

    localparam int unsigned FRAME_LEN = 7;
    // bytes held between transactions; a seventh byte always resolves the window
    localparam int unsigned WIN_DEPTH = FRAME_LEN - 1;
    localparam int unsigned FILL_W    = $clog2(FRAME_LEN);

    localparam logic [7:0] START_BYTE = 8'h5A;
    localparam logic [7:0] END_BYTE   = 8'h15;

    localparam logic MODE_PLAIN    = 1'b0;
    localparam logic MODE_WEIGHTED = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte front_pos;
        t_byte back_pos;
        t_byte tilt_angle;
        t_byte quadrant_code;
    } t_frame;

    typedef struct packed {
        logic  vld;
        t_byte data;
    } t_byte_xfer;

    typedef struct packed {
        logic   vld;
        t_frame frame;
    } t_res_xfer;

    // low byte of the payload sum, third byte counted twice in weighted mode
    function automatic t_byte f_frame_check(input logic mode, input t_byte p0,
                                            input t_byte p1, input t_byte p2,
                                            input t_byte p3);
        t_byte sum;
        sum = p0 + p1 + p2 + p3;
        if (mode == MODE_WEIGHTED) begin
            sum = sum + p2;
        end
        return sum;
    endfunction

endpackage

/* sv/sfd_if.sv */
// valid/ready channels of the sensor frame deframer
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] front_pos;
    logic [7:0] back_pos;
    logic [7:0] tilt_angle;
    logic [7:0] quadrant_code;

    modport source (output valid, output front_pos, output back_pos, output tilt_angle,
                    output quadrant_code, input ready);
    modport sink (input valid, input front_pos, input back_pos, input tilt_angle,
                  input quadrant_code, output ready);
endinterface

/* sv/sfd_in_stage.sv */
// input register of the byte channel
module sfd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sfd_byte_if.sink            i_rx,
    input  logic                i_adv,
    output sfd_pkg::t_byte_xfer o_xfer
);

    logic           r_vld;
    sfd_pkg::t_byte r_byte;

    assign i_rx.ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_xfer.vld  = r_vld && i_adv;
    assign o_xfer.data = r_byte;

endmodule

/* sv/sfd_window.sv */
// byte window, frame search and check
module sfd_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  sfd_pkg::t_byte_xfer i_xfer,
    output sfd_pkg::t_res_xfer  o_res
);

    localparam logic [sfd_pkg::FILL_W-1:0] FILL_FULL = sfd_pkg::FILL_W'(sfd_pkg::WIN_DEPTH);
    localparam logic [sfd_pkg::FILL_W-1:0] FILL_SPAN = sfd_pkg::FILL_W'(sfd_pkg::FRAME_LEN);
    localparam logic [sfd_pkg::FILL_W-1:0] FILL_ONE  = sfd_pkg::FILL_W'(1);

    logic                        r_mode;
    sfd_pkg::t_byte              r_win [0:sfd_pkg::WIN_DEPTH-1];
    sfd_pkg::t_byte              n_win [0:sfd_pkg::WIN_DEPTH-1];
    logic [sfd_pkg::FILL_W-1:0]  r_fill;
    logic [sfd_pkg::FILL_W-1:0]  n_fill;
    sfd_pkg::t_byte              w [0:sfd_pkg::FRAME_LEN-1];
    logic                        found;
    logic [sfd_pkg::FILL_W-1:0]  sel;
    logic                        chk_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sfd_pkg::MODE_PLAIN;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // window with the new byte appended
    always_comb begin
        for (int i = 0; i < sfd_pkg::WIN_DEPTH; i++) begin
            w[i] = (sfd_pkg::FILL_W'(i) == r_fill) ? i_xfer.data : r_win[i];
        end
        w[sfd_pkg::FRAME_LEN-1] = i_xfer.data;
    end

    // first start byte after the leading one of a full window
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int k = 1; k < sfd_pkg::FRAME_LEN; k++) begin
            if (!found && w[k] == sfd_pkg::START_BYTE) begin
                found = 1'b1;
                sel   = sfd_pkg::FILL_W'(k);
            end
        end
    end

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_xfer.vld) begin
            if (r_fill == '0) begin
                n_win[0] = i_xfer.data;
                n_fill   = (i_xfer.data == sfd_pkg::START_BYTE) ? FILL_ONE : '0;
            end else if (r_fill != FILL_FULL) begin
                n_win[r_fill] = i_xfer.data;
                n_fill        = r_fill + 1'b1;
            end else if (i_xfer.data == sfd_pkg::END_BYTE) begin
                // complete frame, good or bad, leaves the window empty
                n_fill = '0;
            end else if (found) begin
                // resync on the next start byte
                for (int k = 1; k < sfd_pkg::FRAME_LEN; k++) begin
                    if (sel == sfd_pkg::FILL_W'(k)) begin
                        for (int j = 0; j < sfd_pkg::WIN_DEPTH; j++) begin
                            if (j + k < sfd_pkg::FRAME_LEN) begin
                                n_win[j] = w[j+k];
                            end
                        end
                    end
                end
                n_fill = FILL_SPAN - sel;
            end else begin
                n_fill = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign chk_ok = sfd_pkg::f_frame_check(r_mode, r_win[1], r_win[2], r_win[3], r_win[4])
                    == r_win[5];

    assign o_res.vld = i_xfer.vld && (r_fill == FILL_FULL)
                       && (i_xfer.data == sfd_pkg::END_BYTE) && chk_ok;
    assign o_res.frame.front_pos     = r_win[1];
    assign o_res.frame.back_pos      = r_win[2];
    assign o_res.frame.tilt_angle    = r_win[3];
    assign o_res.frame.quadrant_code = r_win[4];

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("window fill beyond six bytes");
    a_lead_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (r_win[0] == sfd_pkg::START_BYTE))
        else $error("window does not begin with a start byte");
    a_res_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vld |-> (r_fill == FILL_FULL))
        else $error("result without a full window");
    a_res_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.vld |=> (r_fill == '0))
        else $error("window not cleared after a frame");
`endif

endmodule

/* sv/sfd_out_stage.sv */
// result register of the result channel
module sfd_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_res_xfer i_res,
    sfd_result_if.source       o_res,
    output logic               o_adv
);

    logic            r_vld;
    sfd_pkg::t_frame r_frame;

    // the window may step when the result register is free or being emptied
    assign o_adv = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res.vld) begin
            r_frame <= i_res.frame;
        end
    end

    assign o_res.valid         = r_vld;
    assign o_res.front_pos     = r_frame.front_pos;
    assign o_res.back_pos      = r_frame.back_pos;
    assign o_res.tilt_angle    = r_frame.tilt_angle;
    assign o_res.quadrant_code = r_frame.quadrant_code;

endmodule

/* sv/sensor_frame_deframer.sv */
// top level of the sensor frame deframer
//
// usage:
//   i_rx carries one received byte per transaction (valid/ready). the block
//   looks for 7-byte frames: 0x5A, four payload bytes, check byte, 0x15.
//   o_res carries one transaction per frame whose check byte matches the
//   low 8 bits of the payload sum (third payload byte counted twice when
//   checksum_mode is 1). bad frames and stray bytes give no transaction.
//   i_cfg_we/i_cfg_wdata write checksum_mode; write only while idle.
// timing:
//   one byte per cycle while o_res takes its results. a byte accepted
//   into the input register is folded into the window when the window
//   steps, and a result it completes is loaded into the result register
//   in that same step. the rate is set by the window update loop.
// reset (i_rst_n low, synchronous): window emptied, checksum_mode to 0,
//   both channel registers empty.
// stall: when o_res holds a result that is not taken, the window stops;
//   the input register holds at most one byte and i_rx.ready is low while full.
module sensor_frame_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    sfd_byte_if.sink     i_rx,
    sfd_result_if.source o_res
);

    sfd_pkg::t_byte_xfer byte_xfer;
    sfd_pkg::t_res_xfer  res_xfer;
    logic                adv;

    // input register
    sfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_adv   (adv),
        .o_xfer  (byte_xfer)
    );

    // window update, resync and check
    sfd_window u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_xfer      (byte_xfer),
        .o_res       (res_xfer)
    );

    // result register and stall control
    sfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_xfer),
        .o_res   (o_res),
        .o_adv   (adv)
    );

endmodule
